@@ hdl/rvex_pkg.sv @@
// Shared types and constants for the RV32I integer execute block.
package rvex_pkg;

	localparam int unsigned XLEN      = 32;
	localparam int unsigned REG_COUNT = 32;
	localparam int unsigned REG_AW    = $clog2(REG_COUNT);

	typedef logic [XLEN-1:0]   word_t;
	typedef logic [REG_AW-1:0] reg_addr_t;

	typedef enum logic [6:0] {
		OPC_OP    = 7'h33,
		OPC_OPIMM = 7'h13,
		OPC_LUI   = 7'h37,
		OPC_AUIPC = 7'h17,
		OPC_JAL   = 7'h6F,
		OPC_JALR  = 7'h67
	} opcode_t;

	localparam logic [2:0] F3_ADD  = 3'd0;
	localparam logic [2:0] F3_SLL  = 3'd1;
	localparam logic [2:0] F3_SLT  = 3'd2;
	localparam logic [2:0] F3_SLTU = 3'd3;
	localparam logic [2:0] F3_XOR  = 3'd4;
	localparam logic [2:0] F3_SRL  = 3'd5;
	localparam logic [2:0] F3_OR   = 3'd6;
	localparam logic [2:0] F3_AND  = 3'd7;

	typedef struct packed {
		logic      en;
		reg_addr_t addr;
		word_t     data;
	} rf_write_t;

	typedef struct packed {
		word_t next_pc;
		word_t value;
		logic  write;
		logic  known;
	} exec_result_t;

endpackage

@@ hdl/rvex_regfile.sv @@
// Register file with two registered read ports, write-first bypass and reset valid bits.
module rvex_regfile (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rvex_pkg::rf_write_t   wr,
	input  logic                  rd_en,
	input  rvex_pkg::reg_addr_t   rd_addr_a,
	input  rvex_pkg::reg_addr_t   rd_addr_b,
	output rvex_pkg::word_t       rd_data_a,
	output rvex_pkg::word_t       rd_data_b
);

	rvex_pkg::word_t                  mem [rvex_pkg::REG_COUNT];
	logic [rvex_pkg::REG_COUNT-1:0]   valid_q;
	rvex_pkg::word_t                  rd_data_a_q;
	rvex_pkg::word_t                  rd_data_b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr.addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr.en && wr.addr == rd_addr_a) begin
				rd_data_a_q <= wr.data;
			end else if (valid_q[rd_addr_a]) begin
				rd_data_a_q <= mem[rd_addr_a];
			end else begin
				rd_data_a_q <= '0;
			end
			if (wr.en && wr.addr == rd_addr_b) begin
				rd_data_b_q <= wr.data;
			end else if (valid_q[rd_addr_b]) begin
				rd_data_b_q <= mem[rd_addr_b];
			end else begin
				rd_data_b_q <= '0;
			end
		end
	end

	assign rd_data_a = rd_data_a_q;
	assign rd_data_b = rd_data_b_q;

endmodule

@@ hdl/rvex_exec.sv @@
// Combinational decode, ALU and next-PC logic for one instruction.
module rvex_exec (
	input  logic [31:0]              instruction,
	input  rvex_pkg::word_t          pc,
	input  rvex_pkg::word_t          rs1_data,
	input  rvex_pkg::word_t          rs2_data,
	output rvex_pkg::exec_result_t   result
);

	logic [2:0]      f3;
	logic            f7nz;
	rvex_pkg::word_t imm_i;
	rvex_pkg::word_t imm_u;
	rvex_pkg::word_t imm_j;
	rvex_pkg::word_t pc_plus4;
	rvex_pkg::word_t alu_b;
	logic            alu_alt;
	logic            alu_sub;
	rvex_pkg::word_t alu_out;
	logic [4:0]      shamt;

	assign f3       = instruction[14:12];
	assign f7nz     = |instruction[31:25];
	assign imm_i    = {{20{instruction[31]}}, instruction[31:20]};
	assign imm_u    = {instruction[31:12], 12'h000};
	assign imm_j    = {{11{instruction[31]}}, instruction[31], instruction[19:12],
		instruction[20], instruction[30:21], 1'b0};
	assign pc_plus4 = pc + 32'd4;

	always_comb begin
		alu_b   = rs2_data;
		alu_alt = f7nz;
		alu_sub = f7nz;
		if (instruction[6:0] == rvex_pkg::OPC_OPIMM) begin
			alu_b   = imm_i;
			alu_alt = (f3 == rvex_pkg::F3_SRL) && f7nz;
			alu_sub = 1'b0;
		end
	end

	assign shamt = alu_b[4:0];

	always_comb begin
		unique case (f3)
			rvex_pkg::F3_ADD:  alu_out = alu_sub ? rs1_data - alu_b : rs1_data + alu_b;
			rvex_pkg::F3_SLL:  alu_out = rs1_data << shamt;
			rvex_pkg::F3_SLT:  alu_out = {31'd0, $signed(rs1_data) < $signed(alu_b)};
			rvex_pkg::F3_SLTU: alu_out = {31'd0, rs1_data < alu_b};
			rvex_pkg::F3_XOR:  alu_out = rs1_data ^ alu_b;
			rvex_pkg::F3_SRL:  alu_out = alu_alt ? rvex_pkg::word_t'($signed(rs1_data) >>> shamt)
				: rs1_data >> shamt;
			rvex_pkg::F3_OR:   alu_out = rs1_data | alu_b;
			rvex_pkg::F3_AND:  alu_out = rs1_data & alu_b;
			default:           alu_out = '0;
		endcase
	end

	always_comb begin
		result.next_pc = pc_plus4;
		result.value   = '0;
		result.known   = 1'b1;
		unique case (instruction[6:0])
			rvex_pkg::OPC_OP, rvex_pkg::OPC_OPIMM: begin
				result.value = alu_out;
			end
			rvex_pkg::OPC_LUI: begin
				result.value = imm_u;
			end
			rvex_pkg::OPC_AUIPC: begin
				result.value = pc + imm_u;
			end
			rvex_pkg::OPC_JAL: begin
				result.value   = pc_plus4;
				result.next_pc = pc + imm_j;
			end
			rvex_pkg::OPC_JALR: begin
				result.value   = pc_plus4;
				result.next_pc = (rs1_data + imm_i) & ~32'd1;
			end
			default: begin
				result.known = 1'b0;
			end
		endcase
		result.write = result.known && (instruction[11:7] != 5'd0);
		if (!result.write) begin
			result.value = '0;
		end
	end

endmodule

@@ hdl/rv32i_alu_jump_execute.sv @@
// Top level of the RV32I integer execute block: input stage, PC, register file and result register.
// One instruction is accepted per cycle while out_ready is high. An accepted instruction is held in
// an input register together with its two source operands, read from the register file at the edge
// of acceptance; in the next cycle it is executed and its result loaded into the result register
// unless out_ready holds it back, so the block sustains one instruction per clock. The rate is set
// by the register file write-first bypass, which hands a result straight to the source read of the
// instruction accepted at the same edge. Writing cfg_write_data loads the program counter at once;
// reset clears the PC and the valid bits, so registers read zero until written; x0 always reads zero.
module rv32i_alu_jump_execute (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write_en,
	input  logic [31:0] cfg_write_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] instruction,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] next_pc,
	output logic [4:0]  dest_index,
	output logic [31:0] dest_value,
	output logic        dest_write,
	output logic        unknown_op
);

	logic                   valid_s1;
	logic [31:0]            instruction_s1;
	rvex_pkg::word_t        rs1_data_s1;
	rvex_pkg::word_t        rs2_data_s1;
	rvex_pkg::word_t        pc_q;
	rvex_pkg::exec_result_t result;
	rvex_pkg::rf_write_t    rf_wr;
	logic                   accept;
	logic                   advance;

	logic                   out_valid_q;
	logic [31:0]            next_pc_q;
	logic [4:0]             dest_index_q;
	logic [31:0]            dest_value_q;
	logic                   dest_write_q;
	logic                   unknown_op_q;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign accept   = in_valid && in_ready;

	rvex_regfile u_regfile (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (rf_wr),
		.rd_en     (accept),
		.rd_addr_a (instruction[19:15]),
		.rd_addr_b (instruction[24:20]),
		.rd_data_a (rs1_data_s1),
		.rd_data_b (rs2_data_s1)
	);

	rvex_exec u_exec (
		.instruction (instruction_s1),
		.pc          (pc_q),
		.rs1_data    (rs1_data_s1),
		.rs2_data    (rs2_data_s1),
		.result      (result)
	);

	assign rf_wr.en   = advance && result.write;
	assign rf_wr.addr = instruction_s1[11:7];
	assign rf_wr.data = result.value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			instruction_s1 <= instruction;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
		end else if (cfg_write_en) begin
			pc_q <= cfg_write_data;
		end else if (advance) begin
			pc_q <= result.next_pc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			next_pc_q    <= result.next_pc;
			dest_index_q <= instruction_s1[11:7];
			dest_value_q <= result.value;
			dest_write_q <= result.write;
			unknown_op_q <= !result.known;
		end
	end

	assign out_valid  = out_valid_q;
	assign next_pc    = next_pc_q;
	assign dest_index = dest_index_q;
	assign dest_value = dest_value_q;
	assign dest_write = dest_write_q;
	assign unknown_op = unknown_op_q;

`ifndef SYNTHESIS
	a_no_x0_write: assert property (@(posedge clk) disable iff (!arst_n)
		rf_wr.en |-> rf_wr.addr != 5'd0)
		else $error("register file write to x0");

	a_write_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(dest_write && (unknown_op || dest_index == 5'd0)))
		else $error("destination write with unknown opcode or x0");

	a_no_write_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !dest_write) |-> dest_value == 32'd0)
		else $error("nonzero destination value without a write");

	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1 && $stable(instruction_s1))
		else $error("stalled input stage lost its instruction");
`endif

endmodule
